@@ design/hashed_timing_wheel_assert.svh @@
// Assertion macros for the timing wheel checker
`ifndef HASHED_TIMING_WHEEL_ASSERT_SVH
`define HASHED_TIMING_WHEEL_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off in reset
`define HTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/htw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

    // field widths
    localparam int ACTION_W   = 2;
    localparam int PERIOD_W   = 20;
    localparam int ID_W       = 32;
    localparam int TIME_W     = 64;
    localparam int KIND_W     = 2;
    localparam int ROUNDS_W   = 10;
    localparam int TICK_W     = 32;
    localparam int ADDR_W     = 3;

    // expiry report limit per beat and its counter
    localparam int REPORT_LIMIT = 32;
    localparam int REP_CNT_W    = 6;

    localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = 10'd1023;
    localparam logic [TICK_W-1:0]   TICK_RST   = 32'd1000;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [KIND_W-1:0]   t_kind;

    // input actions
    localparam t_action ACT_ADD        = 2'd0;
    localparam t_action ACT_CANCEL     = 2'd1;
    localparam t_action ACT_CANCEL_ALL = 2'd2;
    localparam t_action ACT_TIME       = 2'd3;

    // result kinds
    localparam t_kind KIND_ADD    = 2'd0;
    localparam t_kind KIND_CANCEL = 2'd1;
    localparam t_kind KIND_EXPIRE = 2'd2;

    // register index of tick_interval (paddr bit 2)
    localparam logic REG_TICK = 1'b0;

    // divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

`default_nettype wire

@@ design/htw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// input channel
interface htw_in_if;
    import htw_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PERIOD_W-1:0] period_seconds;
    logic                periodic;
    logic [ID_W-1:0]     cancel_id;
    logic [TIME_W-1:0]   now_time;

    modport source (output valid, action, period_seconds, periodic, cancel_id, now_time,
                    input ready);
    modport sink   (input valid, action, period_seconds, periodic, cancel_id, now_time,
                    output ready);
endinterface

// result channel
interface htw_out_if;
    import htw_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [ID_W-1:0]   timer_id;
    logic              ok;
    logic              last;

    modport source (output valid, result_kind, timer_id, ok, last, input ready);
    modport sink   (input valid, result_kind, timer_id, ok, last, output ready);
endinterface

`default_nettype wire

@@ design/htw_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Period split by the slot count through a reciprocal multiply, three pipeline stages:
// product, quotient, then remainder and saturated rounds. Done rises as the remainder and rounds are registered.
module htw_div
    import htw_pkg::*;
#(
    parameter int WHEEL_SLOTS = 1024,
    parameter int SW          = 10
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  t_div_ctl      i_ctl,
    output t_div_ctl            o_ctl,
    input  wire  [PERIOD_W-1:0] i_period,
    output logic [SW-1:0]       o_rem,
    output logic [ROUNDS_W-1:0] o_rounds
);

    // reciprocal exact for every PERIOD_W-bit period, SW = ceil(log2(WHEEL_SLOTS))
    localparam int MW  = PERIOD_W + 2;
    localparam int PRW = PERIOD_W + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << (PERIOD_W + SW)) / 64'(WHEEL_SLOTS)) + 64'd1;
    localparam logic [MW-1:0]       RECIP_C = MW'(RECIP);
    localparam logic [PERIOD_W-1:0] W_P     = PERIOD_W'(WHEEL_SLOTS);

    logic [PRW-1:0]      r_prod;
    logic [PERIOD_W-1:0] r_q;
    logic [SW-1:0]       r_rem;
    logic [ROUNDS_W-1:0] r_rounds;
    logic                r_s1;
    logic                r_s2;
    logic                r_done;

    logic [PRW-1:0]      prod_sh;
    logic [PERIOD_W-1:0] rem_w;

    assign prod_sh = r_prod >> (PERIOD_W + SW);
    assign rem_w   = i_period - r_q * W_P;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_ctl.start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_prod <= PRW'(i_period) * PRW'(RECIP_C);
        end
        if (r_s1) begin
            r_q <= prod_sh[PERIOD_W-1:0];
        end
        if (r_s2) begin
            r_rem    <= rem_w[SW-1:0];
            r_rounds <= (|r_q[PERIOD_W-1:ROUNDS_W]) ? ROUNDS_MAX : r_q[ROUNDS_W-1:0];
        end
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
    assign o_rem       = r_rem;
    assign o_rounds    = r_rounds;

endmodule

`default_nettype wire

@@ design/htw_tmem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Timer table: one write port, one read port, registered read data.
module htw_tmem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 80
) (
    input  wire           i_clk,
    input  wire           i_re,
    input  wire  [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  wire           i_we,
    input  wire  [AW-1:0] i_waddr,
    input  wire  [DW-1:0] i_wdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/hashed_timing_wheel.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Hashed timing wheel with WHEEL_SLOTS slots and a table of MAX_TIMERS timers held in a
// one-port-read, one-port-write memory. One input beat is worked at a time. An add with a
// free entry passes the three-stage reciprocal divider that splits the period into slot offset
// and rounds; with the table full it is refused. A cancel or an advancing time update scans the
// table, one entry a cycle while no stall holds it; each slot hit is written back from the
// registered read data, and a slow result sink stalls the scan. Cancel-all and a time update that
// does not advance skip the scan and give no result. Expiries come out in table order, the last
// result of a beat marked by last. The tick interval register sits at byte address 0 of the APB port.
module hashed_timing_wheel
    import htw_pkg::*;
#(
    parameter int WHEEL_SLOTS = 1024,
    parameter int MAX_TIMERS  = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    htw_in_if.sink            i_in,
    htw_out_if.source         o_out,
    input  wire               i_psel,
    input  wire               i_penable,
    input  wire               i_pwrite,
    input  wire  [ADDR_W-1:0] i_paddr,
    input  wire  [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready
);

    localparam int SW = $clog2(WHEEL_SLOTS);
    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1) + 1;
    localparam logic [SW:0] W_C = {1'b0, {SW{1'b0}}} + (SW + 1)'(WHEEL_SLOTS);

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [SW-1:0]       slot;
        logic [ROUNDS_W-1:0] rounds;
        logic [SW-1:0]       off;
        logic [ROUNDS_W-1:0] reload;
        logic                periodic;
    } t_entry;

    localparam int DW = $bits(t_entry);

    // states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ADDW = 3'd2;
    localparam logic [2:0] S_TCHK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]            r_state;
    logic [TICK_W-1:0]     r_tick;
    logic [MAX_TIMERS-1:0] r_valid;
    logic [SW-1:0]         r_cur;
    logic [ID_W-1:0]       r_next_id;
    logic [TIME_W-1:0]     r_last_time;

    // latched beat
    t_action               r_op;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_periodic;
    logic [ID_W-1:0]       r_cancel_id;
    logic [TIME_W-1:0]     r_now;
    logic [IW-1:0]         r_add_ix;
    logic                  r_add_ok;

    // scan pipeline
    logic [CW-1:0]         r_rd_ix;
    logic [IW-1:0]         r_ck_ix;
    logic                  r_ck_vld;
    logic                  r_found;
    logic                  r_pend_vld;
    logic [ID_W-1:0]       r_pend_id;
    logic [REP_CNT_W-1:0]  r_rep_cnt;

    // result register
    logic                  r_out_vld;
    t_kind                 r_out_kind;
    logic [ID_W-1:0]       r_out_id;
    logic                  r_out_ok;
    logic                  r_out_last;

    // free entry search
    logic                  free_any;
    logic [IW-1:0]         free_ix;

    always_comb begin
        free_any = 1'b0;
        free_ix  = '0;
        for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any = 1'b1;
                free_ix  = IW'(k);
            end
        end
    end

    // divider
    t_div_ctl            div_in;
    t_div_ctl            div_out;
    logic [SW-1:0]       div_rem;
    logic [ROUNDS_W-1:0] div_rounds;

    htw_div #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .SW          (SW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (div_in),
        .o_ctl    (div_out),
        .i_period (r_period),
        .o_rem    (div_rem),
        .o_rounds (div_rounds)
    );

    // slot arithmetic: current slot plus an offset, wrapped
    function automatic logic [SW-1:0] wrap_slot(input logic [SW-1:0] cur,
                                                input logic [SW-1:0] off);
        logic [SW:0] sum;
        sum = {1'b0, cur} + {1'b0, off};
        if (sum >= W_C) begin
            sum = sum - W_C;
        end
        return sum[SW-1:0];
    endfunction

    // table memory
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    t_entry        q;

    htw_tmem #(
        .DEPTH (MAX_TIMERS),
        .AW    (IW),
        .DW    (DW)
    ) u_tmem (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

    assign q = t_entry'(mem_rdata);

    // handshakes
    logic in_acc;
    logic out_free;
    logic cfg_wr;

    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || o_out.ready;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    // checked entry decode
    logic hit_valid;
    logic is_cancel;
    logic cancel_hit;
    logic in_slot;
    logic expire;
    logic report;
    logic push;
    logic stall;
    logic rd_more;
    logic scan_end;
    logic fin_go;
    logic out_load;

    assign hit_valid  = r_ck_vld && r_valid[r_ck_ix];
    assign is_cancel  = (r_op == ACT_CANCEL);
    assign cancel_hit = is_cancel && hit_valid && (q.id == r_cancel_id) && !r_found;
    assign in_slot    = !is_cancel && hit_valid && (q.slot == r_cur);
    assign expire     = in_slot && (q.rounds == '0);
    assign report     = expire && (r_rep_cnt < REP_CNT_W'(REPORT_LIMIT));
    assign push       = report && r_pend_vld;
    assign stall      = (r_state == S_SCAN) && push && !out_free;
    assign rd_more    = r_rd_ix < CW'(MAX_TIMERS);
    assign scan_end   = (r_state == S_SCAN) && !stall && !r_ck_vld && !rd_more;
    assign fin_go     = is_cancel ? out_free : (!r_pend_vld || out_free);

    // result register loads a new beat
    assign out_load = ((r_state == S_ADDW) && out_free)
                   || ((r_state == S_SCAN) && !stall && push)
                   || ((r_state == S_FIN) && fin_go && (is_cancel || r_pend_vld));

    assign mem_re    = (r_state == S_SCAN) && !stall && rd_more;
    assign mem_raddr = r_rd_ix[IW-1:0];

    // write port: add fills an entry, scan writes back a slot hit
    logic [ID_W-1:0] n_next_id;

    assign n_next_id = (r_next_id + 1'b1 == '0) ? ID_W'(1) : r_next_id + 1'b1;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ck_ix;
        mem_wdata = q;
        if (r_state == S_ADDW) begin
            mem_we             = r_add_ok && out_free;
            mem_waddr          = r_add_ix;
            mem_wdata.id       = n_next_id;
            mem_wdata.slot     = wrap_slot(r_cur, div_rem);
            mem_wdata.rounds   = div_rounds;
            mem_wdata.off      = div_rem;
            mem_wdata.reload   = div_rounds;
            mem_wdata.periodic = r_periodic;
        end else if ((r_state == S_SCAN) && !stall && in_slot) begin
            mem_we = 1'b1;
            if (expire) begin
                mem_wdata.slot   = wrap_slot(r_cur, q.off);
                mem_wdata.rounds = q.reload;
            end else begin
                mem_wdata.rounds = q.rounds - 1'b1;
            end
        end
    end

    assign div_in.start = (r_state == S_DIV) && !r_add_ok;
    assign div_in.done  = 1'b0;

    // time check
    logic [TIME_W-1:0] diff;
    logic              tick_go;

    assign diff    = r_now - r_last_time;
    assign tick_go = !diff[TIME_W-1] && (diff >= {{(TIME_W - TICK_W){1'b0}}, r_tick});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= TICK_RST;
            r_valid     <= '0;
            r_cur       <= '0;
            r_next_id   <= '0;
            r_last_time <= '0;
            r_ck_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_add_ok    <= 1'b0;
        end else begin
            if (cfg_wr && (i_paddr[2] == REG_TICK)) begin
                r_tick <= i_pwdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in.action)
                            ACT_ADD: begin
                                r_add_ok <= 1'b0;
                                r_state  <= free_any ? S_DIV : S_ADDW;
                            end
                            ACT_CANCEL: begin
                                r_state <= S_SCAN;
                            end
                            ACT_CANCEL_ALL: begin
                                r_valid <= '0;
                            end
                            default: begin
                                r_state <= S_TCHK;
                            end
                        endcase
                    end
                end

                // r_add_ok marks the divider as started
                S_DIV: begin
                    r_add_ok <= 1'b1;
                    if (div_out.done) begin
                        r_state <= S_ADDW;
                    end
                end

                S_ADDW: begin
                    if (out_free) begin
                        r_out_kind <= KIND_ADD;
                        r_out_ok   <= r_add_ok;
                        r_out_last <= 1'b1;
                        r_out_id   <= r_add_ok ? n_next_id : '0;
                        if (r_add_ok) begin
                            r_next_id         <= n_next_id;
                            r_valid[r_add_ix] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_TCHK: begin
                    if (tick_go) begin
                        r_last_time <= r_now;
                        r_state     <= S_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end

                S_SCAN: begin
                    if (!stall) begin
                        r_ck_vld <= mem_re;
                        if (cancel_hit || (expire && !q.periodic)) begin
                            r_valid[r_ck_ix] <= 1'b0;
                        end
                        if (push) begin
                            r_out_kind <= KIND_EXPIRE;
                            r_out_id   <= r_pend_id;
                            r_out_ok   <= 1'b1;
                            r_out_last <= 1'b0;
                        end
                        if (scan_end) begin
                            r_state <= S_FIN;
                        end
                    end
                end

                S_FIN: begin
                    if (fin_go) begin
                        if (is_cancel) begin
                            r_out_kind <= KIND_CANCEL;
                            r_out_id   <= r_cancel_id;
                            r_out_ok   <= r_found;
                            r_out_last <= 1'b1;
                        end else begin
                            r_cur <= (r_cur == SW'(WHEEL_SLOTS - 1)) ? '0 : r_cur + 1'b1;
                            if (r_pend_vld) begin
                                r_out_kind <= KIND_EXPIRE;
                                r_out_id   <= r_pend_id;
                                r_out_ok   <= 1'b1;
                                r_out_last <= 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // beat capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= i_in.action;
            r_period    <= i_in.period_seconds;
            r_periodic  <= i_in.periodic;
            r_cancel_id <= i_in.cancel_id;
            r_now       <= i_in.now_time;
            r_add_ix    <= free_ix;
            r_rd_ix     <= '0;
            r_found     <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_rep_cnt   <= '0;
        end else if ((r_state == S_SCAN) && !stall) begin
            r_ck_ix <= r_rd_ix[IW-1:0];
            if (mem_re) begin
                r_rd_ix <= r_rd_ix + 1'b1;
            end
            if (cancel_hit) begin
                r_found <= 1'b1;
            end
            if (report) begin
                r_pend_vld <= 1'b1;
                r_pend_id  <= q.id;
                r_rep_cnt  <= r_rep_cnt + 1'b1;
            end
        end
    end

    // ports
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_vld;
    assign o_out.result_kind = r_out_kind;
    assign o_out.timer_id    = r_out_id;
    assign o_out.ok          = r_out_ok;
    assign o_out.last        = r_out_last;
    assign o_pready          = 1'b1;
    assign o_prdata          = (i_paddr[2] == REG_TICK) ? r_tick : '0;

endmodule

`default_nettype wire

@@ design/htw_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "hashed_timing_wheel_assert.svh"

// Port-level checks on the timing wheel.
module htw_chk
    import htw_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [KIND_W-1:0] i_out_kind,
    input wire [ID_W-1:0]   i_out_id,
    input wire              i_out_ok,
    input wire              i_out_last
);

    // a good add never hands out id zero
    `HTW_ASSERT_NOW(a_add_id, i_out_valid && (i_out_kind == KIND_ADD) && i_out_ok, i_out_id != '0, "add returned id zero")

    // replies are single results, expiries always ok
    `HTW_ASSERT_NOW(a_reply_last, i_out_valid && (i_out_kind == KIND_ADD || i_out_kind == KIND_CANCEL), i_out_last, "reply without last")

    `HTW_ASSERT_NOW(a_kind, i_out_valid && (i_out_kind != KIND_ADD) && (i_out_kind != KIND_CANCEL), (i_out_kind == KIND_EXPIRE) && i_out_ok, "bad result kind")

    // stalled result beat holds its id and last
    `HTW_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_id) && $stable(i_out_last), "result beat dropped while stalled")

endmodule

bind hashed_timing_wheel htw_chk u_htw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.result_kind),
    .i_out_id    (o_out.timer_id),
    .i_out_ok    (o_out.ok),
    .i_out_last  (o_out.last)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import htw_pkg::*;

    localparam int SLOTS  = 1024;
    localparam int NTIMER = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_psel = 1'b0;
    logic i_penable = 1'b0;
    logic i_pwrite = 1'b0;
    logic [ADDR_W-1:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic o_pready;

    htw_in_if  in_ch();
    htw_out_if out_ch();

    hashed_timing_wheel dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite), .i_paddr(i_paddr),
        .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready)
    );

    always #6 i_clk = ~i_clk;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] id;
        logic        ok;
        logic        last;
    } t_reply;

    // wheel shadow state
    logic [31:0] m_tick;
    logic        m_valid [NTIMER];
    logic [31:0] m_id [NTIMER];
    logic [9:0]  m_slot [NTIMER];
    logic [9:0]  m_rounds [NTIMER];
    logic [19:0] m_period [NTIMER];
    logic        m_periodic [NTIMER];
    logic [9:0]  m_cur;
    logic [31:0] m_next_id;
    logic [63:0] m_last_time;

    t_reply pending_replies[$];
    int     err_cnt = 0;
    bit     idle_on = 1'b1;
    bit     hold_sink = 1'b0;

    task automatic report(input string what);
        err_cnt++;
        $display("mismatch: %s", what);
    endtask

    function automatic logic [9:0] slot_for(input logic [19:0] p);
        return 10'((m_cur + (p % SLOTS)) % SLOTS);
    endfunction

    function automatic logic [9:0] rounds_for(input logic [19:0] p);
        logic [19:0] r;
        r = p / SLOTS;
        return (r > 20'(ROUNDS_MAX)) ? ROUNDS_MAX : r[9:0];
    endfunction

    // advance the shadow wheel by one input beat and queue its replies
    task automatic predict_wheel(input t_action act, input logic [19:0] per, input logic pdc,
                                 input logic [31:0] cid, input logic [63:0] now);
        t_reply r;
        int fi;
        int n;
        logic [63:0] diff;
        fi = -1;
        n = 0;
        case (act)
            ACT_ADD: begin
                for (int i = 0; i < NTIMER; i++)
                    if (!m_valid[i] && fi < 0) fi = i;
                if (fi < 0) begin
                    r = '{KIND_ADD, 32'd0, 1'b0, 1'b1};
                end else begin
                    m_next_id = m_next_id + 1;
                    if (m_next_id == 0) m_next_id = 1;
                    m_valid[fi] = 1'b1;
                    m_id[fi] = m_next_id;
                    m_slot[fi] = slot_for(per);
                    m_rounds[fi] = rounds_for(per);
                    m_period[fi] = per;
                    m_periodic[fi] = pdc;
                    r = '{KIND_ADD, m_next_id, 1'b1, 1'b1};
                end
                pending_replies.insert(pending_replies.size(), r);
            end
            ACT_CANCEL: begin
                r = '{KIND_CANCEL, cid, 1'b0, 1'b1};
                for (int i = 0; i < NTIMER; i++)
                    if (m_valid[i] && m_id[i] == cid && !r.ok) begin
                        m_valid[i] = 1'b0;
                        r.ok = 1'b1;
                    end
                pending_replies.insert(pending_replies.size(), r);
            end
            ACT_CANCEL_ALL: begin
                for (int i = 0; i < NTIMER; i++) m_valid[i] = 1'b0;
            end
            default: begin
                diff = now - m_last_time;
                if (!diff[63] && diff >= 64'(m_tick)) begin
                    m_last_time = now;
                    for (int i = 0; i < NTIMER; i++) begin
                        if (m_valid[i] && m_slot[i] == m_cur) begin
                            if (m_rounds[i] == 0) begin
                                if (n > 0) pending_replies[$].last = 1'b0;
                                r = '{KIND_EXPIRE, m_id[i], 1'b1, 1'b1};
                                pending_replies.insert(pending_replies.size(), r);
                                n++;
                                if (m_periodic[i]) begin
                                    m_slot[i] = slot_for(m_period[i]);
                                    m_rounds[i] = rounds_for(m_period[i]);
                                end else begin
                                    m_valid[i] = 1'b0;
                                end
                            end else begin
                                m_rounds[i] = m_rounds[i] - 1;
                            end
                        end
                    end
                    m_cur = (m_cur == SLOTS - 1) ? 10'd0 : m_cur + 1;
                end
            end
        endcase
    endtask

    // send one input beat; valid stays up until the caller idles or sends again
    task automatic send_beat(input t_action act, input logic [19:0] per, input logic pdc,
                             input logic [31:0] cid, input logic [63:0] now);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.period_seconds <= per;
        in_ch.periodic <= pdc;
        in_ch.cancel_id <= cid;
        in_ch.now_time <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_wheel(act, per, pdc, cid, now);
        @(negedge i_clk);
    endtask

    task automatic drain_replies();
        in_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [31:0] val);
        i_psel <= 1'b1;
        i_pwrite <= 1'b1;
        i_paddr <= '0;
        i_pwdata <= val;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        m_tick = val;
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
    endtask

    task automatic set_tick(input logic [31:0] val);
        drain_replies();
        apb_write(val);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_replies.size() == 0) begin
                report($sformatf("unexpected result id %0d", out_ch.timer_id));
            end else begin
                want = pending_replies.pop_front();
                if (out_ch.result_kind != want.kind)
                    report($sformatf("kind %0d want %0d", out_ch.result_kind, want.kind));
                if (out_ch.timer_id != want.id)
                    report($sformatf("id %0d want %0d", out_ch.timer_id, want.id));
                if (out_ch.ok != want.ok)
                    report($sformatf("ok %0b want %0b", out_ch.ok, want.ok));
                if (out_ch.last != want.last)
                    report($sformatf("last %0b want %0b", out_ch.last, want.last));
            end
        end
    end

    // sink back-pressure in bursts
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && !hold_sink && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    logic [63:0] clock_now = 64'd0;

    task automatic tick_wheel(input int steps);
        repeat (steps) begin
            clock_now = clock_now + m_tick;
            send_beat(ACT_TIME, '0, 1'b0, '0, clock_now);
        end
    endtask

    task automatic test_directed();
        send_beat(ACT_ADD, 20'd0, 1'b0, '0, '0);
        send_beat(ACT_ADD, 20'd1, 1'b1, '0, '0);
        send_beat(ACT_ADD, 20'd1023, 1'b0, '0, '0);
        send_beat(ACT_ADD, 20'd1024, 1'b1, '0, '0);
        send_beat(ACT_ADD, 20'hFFFFF, 1'b1, '0, '0);
        send_beat(ACT_CANCEL, '0, 1'b0, 32'd3, '0);
        send_beat(ACT_CANCEL, '0, 1'b0, 32'd3, '0);
        send_beat(ACT_CANCEL, '0, 1'b0, 32'hFFFFFFFF, '0);
        // below interval, then advancing ticks
        send_beat(ACT_TIME, '0, 1'b0, '0, 64'd999);
        tick_wheel(3);
        // negative difference is ignored
        send_beat(ACT_TIME, '0, 1'b0, '0, 64'd5);
        send_beat(ACT_TIME, '0, 1'b0, '0, 64'hFFFFFFFFFFFFFFFF);
        send_beat(ACT_CANCEL_ALL, '0, 1'b0, '0, '0);
        // fill the table, then one add too many
        for (int i = 0; i < NTIMER; i++) send_beat(ACT_ADD, 20'(i % 2), 1'(i % 3), '0, '0);
        send_beat(ACT_ADD, 20'd5, 1'b0, '0, '0);
        // zero-period timers expire in the first scan, one-period timers in the second
        tick_wheel(2);
        send_beat(ACT_CANCEL_ALL, '0, 1'b0, '0, '0);
    endtask

    task automatic test_zero_interval();
        set_tick(32'd0);
        send_beat(ACT_ADD, 20'd0, 1'b1, '0, '0);
        send_beat(ACT_TIME, '0, 1'b0, '0, clock_now);
        send_beat(ACT_TIME, '0, 1'b0, '0, clock_now);
        send_beat(ACT_CANCEL_ALL, '0, 1'b0, '0, '0);
        set_tick(32'hFFFFFFFF);
        clock_now = clock_now + 64'hFFFFFFFF;
        send_beat(ACT_TIME, '0, 1'b0, '0, clock_now);
        set_tick(32'd1);
    endtask

    // mostly add/tick traffic with short periods so expiries actually happen
    task automatic test_random(input int count, input logic [31:0] tick);
        int a;
        logic [19:0] p;
        logic [31:0] cid;
        set_tick(tick);
        for (int k = 0; k < count; k++) begin
            a = $urandom_range(0, 99);
            p = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 12));
            if ($urandom_range(0, 7) == 0) p = p + 20'd1024 * 20'($urandom_range(0, 2));
            cid = ($urandom_range(0, 3) == 0) ? $urandom : m_next_id - $urandom_range(0, 8);
            if (a < 35) begin
                send_beat(ACT_ADD, p, 1'($urandom), '0, '0);
            end else if (a < 50) begin
                send_beat(ACT_CANCEL, '0, 1'b0, cid, '0);
            end else if (a < 52) begin
                send_beat(ACT_CANCEL_ALL, 20'($urandom), 1'($urandom), $urandom, {$urandom, $urandom});
            end else if (a < 57) begin
                send_beat(ACT_TIME, p, 1'($urandom), $urandom, {$urandom, $urandom});
                clock_now = m_last_time;
            end else begin
                clock_now = clock_now + tick + 64'($urandom_range(0, 3)) * tick / 2;
                send_beat(ACT_TIME, 20'($urandom), 1'($urandom), $urandom, clock_now);
            end
            if (k == count / 2) begin
                // sender holds off until all results are in
                in_ch.valid <= 1'b0;
                hold_sink = 1'b1;
                @(negedge i_clk);
                while (pending_replies.size() != 0) @(negedge i_clk);
                hold_sink = 1'b0;
            end
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_ADD;
        in_ch.period_seconds = '0;
        in_ch.periodic = 1'b0;
        in_ch.cancel_id = '0;
        in_ch.now_time = '0;
        m_tick = TICK_RST;
        for (int i = 0; i < NTIMER; i++) m_valid[i] = 1'b0;
        m_cur = '0;
        m_next_id = '0;
        m_last_time = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_zero_interval();
        test_random(180, 32'd1);
        test_random(150, 32'd1000);
        idle_on = 1'b0;
        test_random(100, 32'd7);
        drain_replies();
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/htw_pkg.sv
design/htw_if.sv
design/htw_div.sv
design/htw_tmem.sv
design/hashed_timing_wheel.sv
design/htw_chk.sv
tb/tb.sv
